### rtl/led_blink_pattern_generator_defines.svh
// assertion macros shared by the blink channel rtl
`ifndef LED_BLINK_PATTERN_GENERATOR_DEFINES_SVH
`define LED_BLINK_PATTERN_GENERATOR_DEFINES_SVH

// same-cycle implication
`define LBPG_ASSERT_IMP(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("lbpg same-cycle check failed");

// next-cycle implication
`define LBPG_ASSERT_NXT(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("lbpg next-cycle check failed");

`endif

### rtl/lbpg_pkg.sv
package lbpg_pkg;

	localparam int unsigned CfgIdxW  = 3;
	localparam int unsigned CfgDataW = 24;
	localparam int unsigned TimeW    = 32;
	localparam int unsigned MsW      = 16;
	localparam int unsigned ColorW   = 24;
	localparam int unsigned BlinkW   = 3;
	localparam int unsigned ActionW  = 2;

	localparam logic [CfgIdxW-1:0] REG_LED_COLOR        = 3'd0;
	localparam logic [CfgIdxW-1:0] REG_REPEAT_COUNT     = 3'd1;
	localparam logic [CfgIdxW-1:0] REG_ON_TIME_MS       = 3'd2;
	localparam logic [CfgIdxW-1:0] REG_GAP_TIME_MS      = 3'd3;
	localparam logic [CfgIdxW-1:0] REG_PAUSE_TIME_MS    = 3'd4;
	localparam logic [CfgIdxW-1:0] REG_BLINKS_PER_GROUP = 3'd5;

	localparam logic [ActionW-1:0] ACT_TICK  = 2'd0;
	localparam logic [ActionW-1:0] ACT_START = 2'd1;
	localparam logic [ActionW-1:0] ACT_STOP  = 2'd2;
	localparam logic [ActionW-1:0] ACT_NONE  = 2'd3;

	localparam logic [BlinkW-1:0] BLINKS_RESET = 3'd1;

endpackage

### rtl/led_blink_pattern_generator.sv
// one led blink channel driven by tick, start and stop items
// input channel: in_valid / in_stall carry action and now_ms (free-running ms time)
// output channel: out_valid / out_stall carry led_lit, led_rgb and running
// configuration: cfg_we with cfg_index and cfg_data writes one register per edge;
//   the user must write only while no item is in flight; the block does not enforce it
// every accepted item gives exactly one result item, in order
// an accepted item goes through the input register, then the state update and
//   result register, which offers the result
// throughput: one item per cycle while the receiver does not stall, set by the combinational state update
//   (one 32-bit subtract for the deadline test, one add for the next deadline)
// when the receiver stalls, the result register holds and the input register
//   still takes one more item; after that in_stall rises until the result drains
// reset clears the channel to inactive and dark, the state and configuration
//   registers to zero and blinks_per_group to one; both pipeline stages come up empty
`include "led_blink_pattern_generator_defines.svh"

module led_blink_pattern_generator (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          cfg_we,
	input  logic [lbpg_pkg::CfgIdxW-1:0]  cfg_index,
	input  logic [lbpg_pkg::CfgDataW-1:0] cfg_data,
	input  logic                          in_valid,
	output logic                          in_stall,
	input  logic [lbpg_pkg::ActionW-1:0]  action,
	input  logic [lbpg_pkg::TimeW-1:0]    now_ms,
	output logic                          out_valid,
	input  logic                          out_stall,
	output logic                          led_lit,
	output logic [lbpg_pkg::ColorW-1:0]   led_rgb,
	output logic                          running
);
	import lbpg_pkg::*;

	logic [ColorW-1:0] led_color_q;
	logic [MsW-1:0]    repeat_count_q;
	logic [MsW-1:0]    on_time_q;
	logic [MsW-1:0]    gap_time_q;
	logic [MsW-1:0]    pause_time_q;
	logic [BlinkW-1:0] blinks_q;

	logic               valid_s1;
	logic [ActionW-1:0] action_s1;
	logic [TimeW-1:0]   now_s1;

	logic              active_q;
	logic              lit_q;
	logic [BlinkW-1:0] blink_idx_q;
	logic [MsW-1:0]    groups_q;
	logic [TimeW-1:0]  deadline_q;

	logic              active_d;
	logic              lit_d;
	logic [BlinkW-1:0] blink_idx_d;
	logic [MsW-1:0]    groups_d;
	logic [TimeW-1:0]  deadline_d;

	logic              valid_s2;
	logic              lit_s2;
	logic [ColorW-1:0] rgb_s2;
	logic              running_s2;

	logic             advance;
	logic             take_in;
	logic [TimeW-1:0] diff;
	logic             reached;
	logic             last_blink;

	assign advance  = valid_s1 && (!valid_s2 || !out_stall);
	assign in_stall = valid_s1 && !advance;
	assign take_in  = in_valid && !in_stall;

	// configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			led_color_q    <= '0;
			repeat_count_q <= '0;
			on_time_q      <= '0;
			gap_time_q     <= '0;
			pause_time_q   <= '0;
			blinks_q       <= BLINKS_RESET;
		end else if (cfg_we) begin
			unique case (cfg_index)
				REG_LED_COLOR:        led_color_q    <= cfg_data;
				REG_REPEAT_COUNT:     repeat_count_q <= cfg_data[MsW-1:0];
				REG_ON_TIME_MS:       on_time_q      <= cfg_data[MsW-1:0];
				REG_GAP_TIME_MS:      gap_time_q     <= cfg_data[MsW-1:0];
				REG_PAUSE_TIME_MS:    pause_time_q   <= cfg_data[MsW-1:0];
				REG_BLINKS_PER_GROUP: blinks_q       <= cfg_data[BlinkW-1:0];
				default: begin
				end
			endcase
		end
	end

	// input register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (take_in) begin
			valid_s1 <= 1'b1;
		end else if (advance) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (take_in) begin
			action_s1 <= action;
			now_s1    <= now_ms;
		end
	end

	assign diff       = now_s1 - deadline_q;
	assign reached    = !diff[TimeW-1];
	assign last_blink = (blinks_q <= BlinkW'(1)) || (blink_idx_q >= blinks_q - BlinkW'(1));

	// state update for the item leaving the input register
	always_comb begin
		active_d    = active_q;
		lit_d       = lit_q;
		blink_idx_d = blink_idx_q;
		groups_d    = groups_q;
		deadline_d  = deadline_q;
		unique case (action_s1)
			ACT_TICK: begin
				if (active_q && reached) begin
					if (!lit_q) begin
						lit_d      = 1'b1;
						deadline_d = now_s1 + TimeW'(on_time_q);
					end else begin
						lit_d = 1'b0;
						if (!last_blink) begin
							deadline_d  = now_s1 + TimeW'(gap_time_q);
							blink_idx_d = blink_idx_q + BlinkW'(1);
						end else begin
							// groups of at most one blink rest for the gap, longer groups pause
							if (blinks_q > BlinkW'(1)) begin
								deadline_d  = now_s1 + TimeW'(pause_time_q);
								blink_idx_d = '0;
							end else begin
								deadline_d = now_s1 + TimeW'(gap_time_q);
							end
							if (groups_q != '0) begin
								groups_d = groups_q - MsW'(1);
								if (groups_q == MsW'(1)) begin
									active_d = 1'b0;
								end
							end
						end
					end
				end
			end
			ACT_START: begin
				active_d    = 1'b1;
				lit_d       = 1'b0;
				blink_idx_d = '0;
				groups_d    = repeat_count_q;
				deadline_d  = now_s1;
			end
			ACT_STOP: begin
				active_d = 1'b0;
				lit_d    = 1'b0;
			end
			ACT_NONE: begin
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			active_q    <= 1'b0;
			lit_q       <= 1'b0;
			blink_idx_q <= '0;
			groups_q    <= '0;
			deadline_q  <= '0;
		end else if (advance) begin
			active_q    <= active_d;
			lit_q       <= lit_d;
			blink_idx_q <= blink_idx_d;
			groups_q    <= groups_d;
			deadline_q  <= deadline_d;
		end
	end

	// result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (advance) begin
			valid_s2 <= 1'b1;
		end else if (!out_stall) begin
			valid_s2 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			lit_s2     <= lit_d;
			rgb_s2     <= lit_d ? led_color_q : '0;
			running_s2 <= active_d;
		end
	end

	assign out_valid = valid_s2;
	assign led_lit   = lit_s2;
	assign led_rgb   = rgb_s2;
	assign running   = running_s2;

	`LBPG_ASSERT_IMP(a_lit_needs_active, clk, arst_n, lit_q, active_q)
	`LBPG_ASSERT_IMP(a_lit_result_running, clk, arst_n, valid_s2 && lit_s2, running_s2)
	`LBPG_ASSERT_IMP(a_dark_result_black, clk, arst_n, valid_s2 && !lit_s2, rgb_s2 == '0)
	`LBPG_ASSERT_NXT(a_advance_fills_result, clk, arst_n, advance, valid_s2)
	`LBPG_ASSERT_NXT(a_stall_holds_input, clk, arst_n, in_stall, valid_s1)

endmodule

### tb/sv/led_blink_pattern_generator_tb.sv
module led_blink_pattern_generator_tb;
	import lbpg_pkg::*;

	typedef struct {
		logic [ActionW-1:0] act;
		logic [TimeW-1:0]   stamp;
	} blink_cmd_t;

	typedef struct packed {
		logic              lit;
		logic [ColorW-1:0] rgb;
		logic              run;
	} led_view_t;

	logic                clk       = 1'b0;
	logic                arst_n    = 1'b0;
	logic                cfg_we    = 1'b0;
	logic [CfgIdxW-1:0]  cfg_index = REG_LED_COLOR;
	logic [CfgDataW-1:0] cfg_data  = '0;
	logic                in_valid  = 1'b0;
	logic                in_stall;
	logic [ActionW-1:0]  action    = ACT_TICK;
	logic [TimeW-1:0]    now_ms    = '0;
	logic                out_valid;
	logic                out_stall = 1'b0;
	logic                led_lit;
	logic [ColorW-1:0]   led_rgb;
	logic                running;

	// register shadows
	logic [ColorW-1:0] cfg_color  = '0;
	logic [MsW-1:0]    cfg_repeat = '0;
	logic [MsW-1:0]    cfg_on     = '0;
	logic [MsW-1:0]    cfg_gap    = '0;
	logic [MsW-1:0]    cfg_pause  = '0;
	logic [BlinkW-1:0] cfg_blinks = BLINKS_RESET;

	// channel state as predicted
	logic              ch_active   = 1'b0;
	logic              ch_lit      = 1'b0;
	logic [BlinkW-1:0] ch_blink    = '0;
	logic [MsW-1:0]    ch_groups   = '0;
	logic [TimeW-1:0]  ch_deadline = '0;

	blink_cmd_t cmd_pending[$];
	led_view_t  led_expected[$];
	blink_cmd_t next_cmd;
	led_view_t  want;

	int errors        = 0;
	int src_idle_pct  = 0;
	int sink_idle_pct = 0;
	int src_gap       = 0;
	int sink_gap      = 0;
	int hold_left     = 0;
	logic hold_req    = 1'b0;
	logic hold_done   = 1'b0;

	led_blink_pattern_generator dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.in_valid  (in_valid),
		.in_stall  (in_stall),
		.action    (action),
		.now_ms    (now_ms),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.led_lit   (led_lit),
		.led_rgb   (led_rgb),
		.running   (running)
	);

	always begin
		#4 clk = 1'b1;
		#4 clk = 1'b0;
	end

	task automatic advance_channel(input logic [ActionW-1:0] act, input logic [TimeW-1:0] stamp);
		logic [TimeW-1:0] lag;
		logic             group_done;
		led_view_t        view;
		group_done = 1'b0;
		lag = stamp - ch_deadline;
		case (act)
			ACT_TICK: begin
				if (ch_active && !lag[TimeW-1]) begin
					if (!ch_lit) begin
						ch_lit = 1'b1;
						ch_deadline = stamp + cfg_on;
					end else begin
						ch_lit = 1'b0;
						if (cfg_blinks > 3'd1 && ch_blink < cfg_blinks - 3'd1) begin
							ch_deadline = stamp + cfg_gap;
							ch_blink = ch_blink + 3'd1;
						end else if (cfg_blinks > 3'd1) begin
							ch_deadline = stamp + cfg_pause;
							ch_blink = '0;
							group_done = 1'b1;
						end else begin
							ch_deadline = stamp + cfg_gap;
							group_done = 1'b1;
						end
						if (group_done && ch_groups != '0) begin
							ch_groups = ch_groups - 16'd1;
							if (ch_groups == '0)
								ch_active = 1'b0;
						end
					end
				end
			end
			ACT_START: begin
				ch_active = 1'b1;
				ch_lit = 1'b0;
				ch_blink = '0;
				ch_groups = cfg_repeat;
				ch_deadline = stamp;
			end
			ACT_STOP: begin
				ch_active = 1'b0;
				ch_lit = 1'b0;
			end
			default: ;
		endcase
		view.lit = ch_lit;
		view.rgb = ch_lit ? cfg_color : '0;
		view.run = ch_active;
		led_expected.push_back(view);
	endtask

	// driver
	always @(posedge clk) begin
		if (!arst_n) begin
			in_valid <= 1'b0;
			action <= ACT_TICK;
			now_ms <= '0;
			src_gap <= 0;
		end else begin
			if (in_valid && !in_stall)
				advance_channel(action, now_ms);
			if (!in_valid || !in_stall) begin
				if (src_gap != 0) begin
					src_gap <= src_gap - 1;
					in_valid <= 1'b0;
				end else if (cmd_pending.size() != 0 && $urandom_range(0, 99) < src_idle_pct) begin
					src_gap <= $urandom_range(0, 11);
					in_valid <= 1'b0;
				end else if (cmd_pending.size() != 0) begin
					next_cmd = cmd_pending.pop_front();
					in_valid <= 1'b1;
					action <= next_cmd.act;
					now_ms <= next_cmd.stamp;
				end else begin
					in_valid <= 1'b0;
				end
			end
		end
	end

	// monitor
	always @(posedge clk) begin
		if (!arst_n) begin
			out_stall <= 1'b0;
			sink_gap <= 0;
			hold_left <= 0;
			hold_done <= 1'b0;
		end else begin
			if (out_valid && !out_stall) begin
				if (led_expected.size() == 0) begin
					$error("result item with nothing expected");
					errors++;
				end else begin
					want = led_expected.pop_front();
					if (led_lit !== want.lit) begin
						$error("led_lit expected %0d actual %0d", want.lit, led_lit);
						errors++;
					end
					if (led_rgb !== want.rgb) begin
						$error("led_rgb expected %06h actual %06h", want.rgb, led_rgb);
						errors++;
					end
					if (running !== want.run) begin
						$error("running expected %0d actual %0d", want.run, running);
						errors++;
					end
				end
			end
			if (hold_left != 0) begin
				hold_left <= hold_left - 1;
				out_stall <= 1'b1;
			end else if (hold_req && !hold_done) begin
				hold_done <= 1'b1;
				hold_left <= 59;
				out_stall <= 1'b1;
			end else if (sink_gap != 0) begin
				sink_gap <= sink_gap - 1;
				out_stall <= 1'b1;
			end else if ($urandom_range(0, 99) < sink_idle_pct) begin
				sink_gap <= $urandom_range(0, 11);
				out_stall <= 1'b1;
			end else begin
				out_stall <= 1'b0;
			end
		end
	end

	task automatic queue_cmd(input logic [ActionW-1:0] act, input logic [TimeW-1:0] stamp);
		blink_cmd_t c;
		c.act = act;
		c.stamp = stamp;
		cmd_pending.push_back(c);
	endtask

	task automatic settle();
		do
			@(negedge clk);
		while (cmd_pending.size() != 0 || in_valid || led_expected.size() != 0);
		repeat (4) @(posedge clk);
	endtask

	task automatic write_reg(input logic [CfgIdxW-1:0] idx, input logic [CfgDataW-1:0] val);
		@(posedge clk);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_data <= val;
		@(posedge clk);
		cfg_we <= 1'b0;
		case (idx)
			REG_LED_COLOR:        cfg_color = val;
			REG_REPEAT_COUNT:     cfg_repeat = val[MsW-1:0];
			REG_ON_TIME_MS:       cfg_on = val[MsW-1:0];
			REG_GAP_TIME_MS:      cfg_gap = val[MsW-1:0];
			REG_PAUSE_TIME_MS:    cfg_pause = val[MsW-1:0];
			REG_BLINKS_PER_GROUP: cfg_blinks = val[BlinkW-1:0];
			default: ;
		endcase
	endtask

	task automatic apply_setting(input logic [ColorW-1:0] color, input logic [MsW-1:0] rep,
			input logic [MsW-1:0] on_t, input logic [MsW-1:0] gap_t,
			input logic [MsW-1:0] pause_t, input logic [BlinkW-1:0] blinks);
		write_reg(REG_LED_COLOR, color);
		write_reg(REG_REPEAT_COUNT, {8'd0, rep});
		write_reg(REG_ON_TIME_MS, {8'd0, on_t});
		write_reg(REG_GAP_TIME_MS, {8'd0, gap_t});
		write_reg(REG_PAUSE_TIME_MS, {8'd0, pause_t});
		write_reg(REG_BLINKS_PER_GROUP, {21'd0, blinks});
	endtask

	initial begin
		int               p;
		int               r;
		logic [TimeW-1:0] clock_ms;
		logic [TimeW-1:0] step_max;
		logic [MsW-1:0]   t_max;

		repeat (9) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// reset settings: zero times, endless, dark colour
		queue_cmd(ACT_TICK, 32'h0000_0000);
		queue_cmd(ACT_START, 32'hFFFF_FFF0);
		queue_cmd(ACT_TICK, 32'hFFFF_FFF0);
		queue_cmd(ACT_TICK, 32'hFFFF_FFFF);
		queue_cmd(ACT_TICK, 32'h0000_0000);
		queue_cmd(ACT_NONE, 32'h0000_0001);
		queue_cmd(ACT_START, 32'h8000_0000);
		queue_cmd(ACT_TICK, 32'h0000_0000);
		queue_cmd(ACT_TICK, 32'h8000_0000);
		queue_cmd(ACT_STOP, 32'h8000_0001);
		queue_cmd(ACT_TICK, 32'h8000_0002);
		settle();

		// groups of three, then group size lowered mid-group
		apply_setting(24'hFFFFFF, 16'd2, 16'd1, 16'd1, 16'd4, 3'd3);
		queue_cmd(ACT_START, 32'd100);
		for (int t = 100; t <= 104; t++)
			queue_cmd(ACT_TICK, t);
		settle();
		write_reg(REG_BLINKS_PER_GROUP, 24'd2);
		queue_cmd(ACT_TICK, 32'd105);
		queue_cmd(ACT_TICK, 32'd106);
		queue_cmd(ACT_TICK, 32'd109);
		queue_cmd(ACT_TICK, 32'd110);
		queue_cmd(ACT_TICK, 32'd111);
		queue_cmd(ACT_TICK, 32'd112);
		queue_cmd(ACT_TICK, 32'd200);
		settle();

		for (p = 0; p < 12; p++) begin
			case (p)
				0: apply_setting(24'hFFFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 3'd7);
				1: apply_setting(24'h000000, 16'h0000, 16'h0000, 16'h0000, 16'h0000, 3'd0);
				default: begin
					if (p % 4 == 3)
						apply_setting(ColorW'($urandom), MsW'($urandom_range(0, 4)),
							MsW'($urandom_range(0, 3000)), MsW'($urandom_range(0, 3000)),
							MsW'($urandom_range(0, 3000)), BlinkW'($urandom_range(0, 7)));
					else
						apply_setting(ColorW'($urandom), MsW'($urandom_range(0, 4)),
							MsW'($urandom_range(0, 12)), MsW'($urandom_range(0, 12)),
							MsW'($urandom_range(0, 12)), BlinkW'($urandom_range(0, 7)));
				end
			endcase
			t_max = cfg_on;
			if (cfg_gap > t_max)
				t_max = cfg_gap;
			if (cfg_pause > t_max)
				t_max = cfg_pause;
			step_max = (t_max >> 1) + 2;

			if (p >= 10) begin
				src_idle_pct = 0;
				sink_idle_pct = 0;
			end else if (p % 3 == 1) begin
				src_idle_pct = 0;
				sink_idle_pct = 0;
			end else begin
				src_idle_pct = (p == 5) ? 0 : $urandom_range(5, 30);
				sink_idle_pct = $urandom_range(5, 30);
			end

			// some phases run on across the time wrap
			if (p % 3 == 0)
				clock_ms = -($urandom_range(0, 40) * step_max);
			else
				clock_ms = $urandom;

			// without a start the previous pattern carries on under the new settings
			if (p == 0 || $urandom_range(0, 1) == 1)
				queue_cmd(ACT_START, clock_ms);
			repeat (130) begin
				r = $urandom_range(0, 99);
				if (r < 6)
					queue_cmd(ACT_START, clock_ms);
				else if (r < 8)
					queue_cmd(ACT_STOP, clock_ms);
				else if (r < 10)
					queue_cmd(ACT_NONE, $urandom);
				else if (r < 12)
					queue_cmd(ACT_TICK, $urandom);
				else begin
					clock_ms = clock_ms + $urandom_range(0, step_max);
					queue_cmd(ACT_TICK, clock_ms);
				end
			end
			if (p == 5)
				hold_req = 1'b1;
			settle();
		end

		if (errors == 0 && led_expected.size() == 0)
			$display("RESULT: OK");
		else
			$display("RESULT: ERROR");
		$finish;
	end

	initial begin
		#4000000;
		$display("RESULT: ERROR");
		$finish;
	end

endmodule
